/* sv/bfm_pkg.sv */
// shared types, constants and helpers of the bloom filter membership block
package bfm_pkg;

    localparam int unsigned DEF_MAX_BINS   = 65536;
    localparam int unsigned DEF_MAX_HASHES = 6;
    localparam int unsigned SEED_SLOTS     = 6;

    localparam int unsigned ELEM_W   = 64;
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned BIN_W    = 17;
    localparam int unsigned HCNT_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned OUT_W    = 8;

    localparam logic [63:0] SECRET_WORD_A = 64'h1CAD21F72C81017C;
    localparam logic [63:0] SECRET_WORD_B = 64'hDB979083E96DD4DE;
    localparam logic [63:0] MIX_PRIME     = 64'h9FB21C651E98DF25;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_COUNT  = 3'd0,
        CFG_HASH_COUNT = 3'd1,
        CFG_SEED_0     = 3'd2,
        CFG_SEED_1     = 3'd3,
        CFG_SEED_2     = 3'd4,
        CFG_SEED_3     = 3'd5,
        CFG_SEED_4     = 3'd6,
        CFG_SEED_5     = 3'd7
    } t_cfg_idx;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* sv/bfm_ram.sv */
// generic single-port ram with registered read
module bfm_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* sv/bloom_filter_membership.sv */
// insert: sets the bit picked by each of k hashes, k the active hash count
// query: checks up to k hashes, it stops at the first clear bit; clear: zeroes all MAX_BINS bits
// per hash: 1 prep, 2 x 3 steps of one shared 32x32 multiplier, 2 mix steps, a bit-serial
// restoring modulo unit over the 64 hash bits, one bit-array access (query: one more check)
// one item at a time; unused action code answers in the cycle after its transaction
// synchronous active-low reset; then a clearing pass over all MAX_BINS bits with s_axis_tready low
module bloom_filter_membership #(
    parameter int unsigned MAX_BINS   = bfm_pkg::DEF_MAX_BINS,
    parameter int unsigned MAX_HASHES = bfm_pkg::DEF_MAX_HASHES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bfm_pkg::ELEM_W-1:0]    s_axis_tdata,   // element
    input  logic [bfm_pkg::ACT_W-1:0]     s_axis_tuser,   // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bfm_pkg::OUT_W-1:0]     m_axis_tdata,   // is_member, zero pad
    input  logic                          i_cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bfm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned AW  = $clog2(MAX_BINS);
    localparam int unsigned EW  = $clog2(MAX_BINS + 1);
    localparam int unsigned MW  = (EW > bfm_pkg::BIN_W) ? EW : bfm_pkg::BIN_W;
    localparam logic [MW-1:0] MAXB = MW'(MAX_BINS);
    localparam logic [AW-1:0] LAST = AW'(MAX_BINS - 1);
    localparam logic [bfm_pkg::HCNT_W-1:0] MAXH = bfm_pkg::HCNT_W'(MAX_HASHES);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_MIX, S_DIV, S_ACC, S_CHK, S_CLR
    } t_state;

    t_state r_state;
    logic [bfm_pkg::BIN_W-1:0]  r_bin;
    logic [bfm_pkg::HCNT_W-1:0] r_hcnt;
    logic [63:0] r_seed [bfm_pkg::SEED_SLOTS];
    logic [1:0]  r_act;
    logic [63:0] r_elem;
    logic [63:0] r_h;
    logic [63:0] r_acc;
    logic [1:0]  r_mstep;
    logic        r_pass;
    logic [5:0]  r_dcnt;
    logic [MW:0] r_rem;
    logic [bfm_pkg::HCNT_W-1:0] r_idx;
    logic [AW-1:0] r_clr;
    logic        r_clr_rsp;
    logic        r_out_valid;
    logic        r_out_bit;

    logic [MW-1:0] m_eff;
    logic [bfm_pkg::HCNT_W-1:0] k_eff;
    logic [63:0] seed_s, flip, h0, h_prep;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [MW:0] div_sh;
    logic        out_free;
    logic        ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    always_comb begin
        if (r_bin == '0) begin
            m_eff = MW'(1);
        end else if (MW'(r_bin) > MAXB) begin
            m_eff = MAXB;
        end else begin
            m_eff = MW'(r_bin);
        end
        if (r_hcnt == '0) begin
            k_eff = bfm_pkg::HCNT_W'(1);
        end else if (r_hcnt > MAXH) begin
            k_eff = MAXH;
        end else begin
            k_eff = r_hcnt;
        end
    end

    // seeded xxh3 front end for an 8-byte input
    always_comb begin
        seed_s = r_seed[r_idx] ^ {bfm_pkg::swap32(r_seed[r_idx][31:0]), 32'd0};
        flip   = (bfm_pkg::SECRET_WORD_A ^ bfm_pkg::SECRET_WORD_B) - seed_s;
        h0     = {r_elem[31:0], r_elem[63:32]} ^ flip;
        h_prep = h0 ^ {h0[14:0], h0[63:15]} ^ {h0[39:0], h0[63:40]};
    end

    // 64x64 low product from three 32x32 partial products
    always_comb begin
        case (r_mstep)
            2'd0: begin
                mul_a = r_h[31:0];
                mul_b = bfm_pkg::MIX_PRIME[31:0];
            end
            2'd1: begin
                mul_a = r_h[31:0];
                mul_b = bfm_pkg::MIX_PRIME[63:32];
            end
            default: begin
                mul_a = r_h[63:32];
                mul_b = bfm_pkg::MIX_PRIME[31:0];
            end
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb begin
        div_sh = {r_rem[MW-1:0], r_h[63]};
        if (div_sh >= {1'b0, m_eff}) begin
            div_sh = div_sh - {1'b0, m_eff};
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = r_rem[AW-1:0];
        case (r_state)
            S_ACC: begin
                ram_we    = (r_act == bfm_pkg::ACT_INSERT);
                ram_wdata = 1'b1;
            end
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
            end
            default: ;
        endcase
    end

    bfm_ram #(.WIDTH(1), .DEPTH(MAX_BINS)) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_clr_rsp   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_bit   <= 1'b0;
            r_bin       <= bfm_pkg::BIN_W'(65536);
            r_hcnt      <= bfm_pkg::HCNT_W'(1);
            for (int i = 0; i < bfm_pkg::SEED_SLOTS; i++) begin
                r_seed[i] <= 64'd1;
            end
            r_idx   <= '0;
            r_mstep <= '0;
            r_pass  <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bfm_pkg::CFG_BIN_COUNT:  r_bin <= i_cfg_data[bfm_pkg::BIN_W-1:0];
                    bfm_pkg::CFG_HASH_COUNT: r_hcnt <= i_cfg_data[bfm_pkg::HCNT_W-1:0];
                    bfm_pkg::CFG_SEED_0:     r_seed[0] <= i_cfg_data;
                    bfm_pkg::CFG_SEED_1:     r_seed[1] <= i_cfg_data;
                    bfm_pkg::CFG_SEED_2:     r_seed[2] <= i_cfg_data;
                    bfm_pkg::CFG_SEED_3:     r_seed[3] <= i_cfg_data;
                    bfm_pkg::CFG_SEED_4:     r_seed[4] <= i_cfg_data;
                    bfm_pkg::CFG_SEED_5:     r_seed[5] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && out_free) begin
                        r_act  <= s_axis_tuser;
                        r_elem <= s_axis_tdata;
                        r_idx  <= '0;
                        case (s_axis_tuser)
                            bfm_pkg::ACT_INSERT, bfm_pkg::ACT_QUERY: begin
                                r_state <= S_PREP;
                            end
                            bfm_pkg::ACT_CLEAR: begin
                                r_clr     <= '0;
                                r_clr_rsp <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            default: begin
                                // unused action code: no effect, answer zero
                                r_out_valid <= 1'b1;
                                r_out_bit   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    r_h     <= h_prep;
                    r_mstep <= '0;
                    r_pass  <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mstep == 2'd0) begin
                        r_acc <= prod;
                    end else begin
                        r_acc <= r_acc + {prod[31:0], 32'd0};
                    end
                    if (r_mstep == 2'd2) begin
                        r_mstep <= '0;
                        r_state <= S_MIX;
                    end else begin
                        r_mstep <= r_mstep + 2'd1;
                    end
                end
                S_MIX: begin
                    if (!r_pass) begin
                        r_h     <= r_acc ^ ((r_acc >> 35) + 64'd8);
                        r_pass  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_h     <= r_acc ^ (r_acc >> 28);
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_sh;
                    r_h    <= {r_h[62:0], 1'b0};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_act == bfm_pkg::ACT_QUERY) begin
                        r_state <= S_CHK;
                    end else if (r_idx + 1'b1 == k_eff) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_bit   <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PREP;
                    end
                end
                S_CHK: begin
                    if (!ram_rdata || (r_idx + 1'b1 == k_eff)) begin
                        // read data holds since the address holds
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_bit   <= ram_rdata;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PREP;
                    end
                end
                S_CLR: begin
                    if (r_clr == LAST) begin
                        if (!r_clr_rsp) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_bit   <= 1'b0;
                            r_clr_rsp   <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bfm_pkg::OUT_W-1){1'b0}}, r_out_bit};

endmodule

/* sv/bfm_checker.sv */
// port-level checker for the bloom filter membership block and its bind
module bfm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bfm_pkg::OUT_W-1:0]     m_axis_tdata
);

    // a transaction is taken only when the result register can take its answer
    a_room_for_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("input accepted while the result register is blocked");

    // clearing pass after reset keeps the input closed
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[bfm_pkg::OUT_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind bloom_filter_membership bfm_checker u_bfm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/tb_bloom_filter_membership.sv */
// testbench of the bloom filter membership block: stream stimulus, own filter model, checking
module tb_bloom_filter_membership;

    localparam int unsigned LIMIT_CYCLES = 20000000;
    localparam int unsigned DRAIN_CYCLES = 600;
    localparam int unsigned BIT_AW = $clog2(bfm_pkg::DEF_MAX_BINS);
    localparam logic [bfm_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [bfm_pkg::ACT_W-1:0]  act;
        logic [bfm_pkg::ELEM_W-1:0] elem;
        logic                       member;
    } t_verdict;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bfm_pkg::ELEM_W-1:0]    s_axis_tdata = '0;   // element
    logic [bfm_pkg::ACT_W-1:0]     s_axis_tuser = '0;   // action
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bfm_pkg::OUT_W-1:0]     m_axis_tdata;        // is_member, zero pad
    logic                          i_cfg_we = 1'b0;
    logic [bfm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [bfm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    bloom_filter_membership u_top (.*);

    always #1 i_clk = ~i_clk;

    // filter model state and configuration
    bit          filter_bits [bfm_pkg::DEF_MAX_BINS];
    logic [16:0] bins_reg;
    logic [2:0]  hashes_reg;
    logic [63:0] seed_reg [bfm_pkg::SEED_SLOTS];

    t_verdict        verdicts [$];
    logic [63:0]     inserted [$];
    int unsigned     fail_cnt = 0;
    int unsigned     cycle_cnt = 0;
    int unsigned     send_idle = 0;
    int unsigned     recv_stall = 0;
    int unsigned     hold_cnt = 0;
    bit              hold_req = 0;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // seeded xxh3 of an 8-byte little-endian word
    function automatic logic [63:0] xxh3_word(input logic [63:0] x, input logic [63:0] seed);
        logic [63:0] s, h;
        s = seed ^ {seed[7:0], seed[15:8], seed[23:16], seed[31:24], 32'h0};
        h = {x[31:0], x[63:32]} ^ ((bfm_pkg::SECRET_WORD_A ^ bfm_pkg::SECRET_WORD_B) - s);
        h = h ^ rotl(h, 49) ^ rotl(h, 24);
        h = h * bfm_pkg::MIX_PRIME;
        h = h ^ ((h >> 35) + 64'd8);
        h = h * bfm_pkg::MIX_PRIME;
        return h ^ (h >> 28);
    endfunction

    // applies one transaction to the filter model, returns the membership answer
    function automatic logic apply_filter(input logic [bfm_pkg::ACT_W-1:0] act,
                                          input logic [63:0] x);
        logic [63:0] m, pick;
        int          k;
        logic        member;
        m = (bins_reg == 0) ? 64'd1 :
            (bins_reg > bfm_pkg::DEF_MAX_BINS) ? 64'(bfm_pkg::DEF_MAX_BINS) : 64'(bins_reg);
        k = (hashes_reg == 0) ? 1 :
            (hashes_reg > bfm_pkg::DEF_MAX_HASHES) ? bfm_pkg::DEF_MAX_HASHES : hashes_reg;
        member = 1'b0;
        if (act == bfm_pkg::ACT_INSERT) begin
            for (int i = 0; i < k; i++) begin
                pick = xxh3_word(x, seed_reg[i]) % m;
                filter_bits[pick[BIT_AW-1:0]] = 1'b1;
            end
        end else if (act == bfm_pkg::ACT_QUERY) begin
            member = 1'b1;
            for (int i = 0; i < k; i++) begin
                pick = xxh3_word(x, seed_reg[i]) % m;
                if (!filter_bits[pick[BIT_AW-1:0]]) member = 1'b0;
            end
        end else if (act == bfm_pkg::ACT_CLEAR) begin
            foreach (filter_bits[i]) filter_bits[i] = 1'b0;
        end
        return member;
    endfunction

    task automatic send_item(input logic [bfm_pkg::ACT_W-1:0] act, input logic [63:0] x);
        t_verdict v;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= x;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        v.act = act;
        v.elem = x;
        v.member = apply_filter(act, x);
        verdicts.insert(verdicts.size(), v);
        if (act == bfm_pkg::ACT_INSERT) begin
            inserted.insert(inserted.size(), x);
            if (inserted.size() > 64) void'(inserted.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bfm_pkg::t_cfg_idx idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            bfm_pkg::CFG_BIN_COUNT:  bins_reg = val[16:0];
            bfm_pkg::CFG_HASH_COUNT: hashes_reg = val[2:0];
            default:                 seed_reg[3'(idx - bfm_pkg::CFG_SEED_0)] = val;
        endcase
    endtask

    task automatic write_seeds_random();
        for (int i = 0; i < bfm_pkg::SEED_SLOTS; i++)
            write_reg(bfm_pkg::t_cfg_idx'(bfm_pkg::CFG_SEED_0 + i), {$urandom, $urandom});
    endtask

    function automatic logic [63:0] pick_element();
        if (inserted.size() != 0 && $urandom_range(1))
            return inserted[$urandom_range(inserted.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    // default configuration after reset, element extremes and the unused action code
    task automatic test_defaults();
        send_item(bfm_pkg::ACT_QUERY, 64'h0);
        send_item(bfm_pkg::ACT_INSERT, 64'h0);
        send_item(bfm_pkg::ACT_QUERY, 64'h0);
        send_item(bfm_pkg::ACT_QUERY, '1);
        send_item(bfm_pkg::ACT_INSERT, '1);
        send_item(bfm_pkg::ACT_QUERY, '1);
        send_item(ACT_UNUSED, 64'h5555_AAAA_5555_AAAA);
        send_item(bfm_pkg::ACT_QUERY, 64'hAAAA_5555_AAAA_5555);
        send_item(bfm_pkg::ACT_QUERY, 64'h8000_0000_0000_0001);
        wait_drained();
    endtask

    // zero and oversized counts, seed extremes, clear covering the whole array
    task automatic test_config_extremes();
        write_reg(bfm_pkg::CFG_BIN_COUNT, 64'h0);
        write_reg(bfm_pkg::CFG_HASH_COUNT, 64'h0);
        send_item(bfm_pkg::ACT_QUERY, 64'h1234);
        send_item(bfm_pkg::ACT_INSERT, 64'h1234);
        send_item(bfm_pkg::ACT_QUERY, 64'hFEDC_BA98_7654_3210);
        wait_drained();
        write_reg(bfm_pkg::CFG_BIN_COUNT, 64'h1FFFF);
        write_reg(bfm_pkg::CFG_HASH_COUNT, 64'h7);
        write_reg(bfm_pkg::CFG_SEED_0, 64'h0);
        write_reg(bfm_pkg::CFG_SEED_1, '1);
        write_reg(bfm_pkg::CFG_SEED_2, 64'h8000_0000_0000_0000);
        write_reg(bfm_pkg::CFG_SEED_3, 64'h0000_0000_FFFF_FFFF);
        write_reg(bfm_pkg::CFG_SEED_4, 64'hFFFF_FFFF_0000_0000);
        write_reg(bfm_pkg::CFG_SEED_5, 64'h0123_4567_89AB_CDEF);
        send_item(bfm_pkg::ACT_INSERT, 64'h0);
        send_item(bfm_pkg::ACT_QUERY, 64'h0);
        send_item(bfm_pkg::ACT_QUERY, '1);
        send_item(bfm_pkg::ACT_CLEAR, '1);
        send_item(bfm_pkg::ACT_QUERY, 64'h0);
        wait_drained();
        // shrinking the bin count keeps the array contents
        write_reg(bfm_pkg::CFG_BIN_COUNT, 64'h1);
        write_reg(bfm_pkg::CFG_HASH_COUNT, 64'h6);
        send_item(bfm_pkg::ACT_QUERY, 64'h77);
        send_item(bfm_pkg::ACT_INSERT, 64'h77);
        wait_drained();
        write_reg(bfm_pkg::CFG_BIN_COUNT, 64'd65536);
        send_item(bfm_pkg::ACT_QUERY, 64'h77);
        send_item(bfm_pkg::ACT_QUERY, 64'h78);
        wait_drained();
    endtask

    // receiver holds off while items keep coming, then sender waits for the drain
    task automatic test_backpressure();
        write_reg(bfm_pkg::CFG_BIN_COUNT, 64'd200);
        write_reg(bfm_pkg::CFG_HASH_COUNT, 64'd2);
        send_idle = 0;
        recv_stall = 0;
        hold_req = 1;
        for (int i = 0; i < 20; i++)
            send_item($urandom_range(1) ? bfm_pkg::ACT_INSERT : bfm_pkg::ACT_QUERY,
                      pick_element());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned idles [4] = '{0, 48, 0, 24};
        int unsigned stalls [4] = '{0, 0, 48, 24};
        int unsigned roll;
        int          clears;
        clears = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_reg(bfm_pkg::CFG_BIN_COUNT, 64'($urandom_range(1, 256)));
                1: write_reg(bfm_pkg::CFG_BIN_COUNT, 64'($urandom_range(0, 131071)));
                2: write_reg(bfm_pkg::CFG_BIN_COUNT, 64'($urandom_range(1, 64)));
                default: write_reg(bfm_pkg::CFG_BIN_COUNT, 64'd65536);
            endcase
            write_reg(bfm_pkg::CFG_HASH_COUNT, 64'($urandom_range(0, 7)));
            write_seeds_random();
            send_idle = idles[ph % 4];
            recv_stall = stalls[ph % 4];
            for (int i = 0; i < 135; i++) begin
                roll = $urandom_range(999);
                if (roll < 4 && clears < 3) begin
                    clears++;
                    send_item(bfm_pkg::ACT_CLEAR, {$urandom, $urandom});
                end else if (roll < 40)
                    send_item(ACT_UNUSED, {$urandom, $urandom});
                else if (roll < 520)
                    send_item(bfm_pkg::ACT_INSERT, {$urandom, $urandom});
                else
                    send_item(bfm_pkg::ACT_QUERY, pick_element());
            end
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 800;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) $display("unexpected transaction: tdata %h", m_axis_tdata);
            end else begin
                v = verdicts.pop_front();
                if (m_axis_tdata !== {7'b0, v.member}) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("is_member mismatch: action %0d element %h expected %h got %h",
                                 v.act, v.elem, {7'b0, v.member}, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("[bloom_filter_membership] ERROR");
            $finish;
        end
    end

    initial begin
        foreach (filter_bits[i]) filter_bits[i] = 1'b0;
        bins_reg = 17'd65536;
        hashes_reg = 3'd1;
        foreach (seed_reg[i]) seed_reg[i] = 64'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        if (fail_cnt == 0) begin
            $display("[bloom_filter_membership] OK");
        end else begin
            $display("[bloom_filter_membership] ERROR");
        end
        $finish;
    end
endmodule
